// ===== rtl/core/tlpf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlpf_pkg: shared types and constants for the three-level priority FIFO
// Field widths, stream packing, operation and status codes, level indexes.
// ----------------------------------------------------------------------------
package tlpf_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int LEVELS        = 3;

    localparam int VALUE_W  = 32;
    localparam int PRIO_W   = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // tdata widths, padded to whole bytes
    localparam int S_TDATA_W = ((VALUE_W + PRIO_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((VALUE_W + COUNT_W + 7) / 8) * 8;

    typedef enum logic [0:0] {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } tlpf_op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_EMPTY   = 2'd2,
        STAT_BADPRIO = 2'd3
    } tlpf_status_t;

    localparam logic [PRIO_W-1:0] PRIO_NONE = 2'd0;

    // ring index of each priority level (priority minus one)
    localparam logic [1:0] LVL_1 = 2'd0;
    localparam logic [1:0] LVL_2 = 2'd1;
    localparam logic [1:0] LVL_3 = 2'd2;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } tlpf_memop_t;

    typedef struct packed {
        tlpf_status_t       status;
        logic [COUNT_W-1:0] total;
        logic               deq_ok;
    } tlpf_resp_t;

endpackage
`default_nettype wire

// ===== rtl/core/tlpf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlpf_ram: generic single-clock RAM
// One write port, one read port, registered read data held between reads.
// ----------------------------------------------------------------------------
module tlpf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 48
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== rtl/core/tlpf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlpf_ctrl: ring pointers, level counts and operation decode
// Decide each item in the cycle it is accepted, update the rings and issue
// the store access.
// ----------------------------------------------------------------------------
module tlpf_ctrl #(
    parameter int DEPTH = tlpf_pkg::DEPTH_DEFAULT
) (
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    input  wire logic                                        op_accept,
    input  wire tlpf_pkg::tlpf_op_t                          op_code,
    input  wire logic [tlpf_pkg::VALUE_W-1:0]                op_value,
    input  wire logic [tlpf_pkg::PRIO_W-1:0]                 op_priority,
    output tlpf_pkg::tlpf_memop_t                            mem_op,
    output logic [$clog2(tlpf_pkg::LEVELS*DEPTH)-1:0]        mem_addr,
    output logic [tlpf_pkg::VALUE_W-1:0]                     mem_wdata,
    output tlpf_pkg::tlpf_resp_t                             resp
);
    import tlpf_pkg::*;

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(LEVELS * DEPTH);

    logic [PTR_W-1:0] head_reg [LEVELS];
    logic [PTR_W-1:0] tail_reg [LEVELS];
    logic [CNT_W-1:0] cnt_reg  [LEVELS];
    logic [CNT_W-1:0] total_reg;
    logic [CNT_W-1:0] total_next;

    logic [1:0]           enq_lv;
    logic [1:0]           deq_lv;
    logic [1:0]           lv_sel;
    logic                 do_enq;
    logic                 do_deq;
    tlpf_status_t         status;
    logic [PTR_W-1:0]     ptr;
    logic [PTR_W-1:0]     ptr_adv;
    logic [CNT_W+4:0]     total_wide;

    always_comb begin
        enq_lv = op_priority - 2'd1;
        // highest non-empty level wins
        if (cnt_reg[LVL_3] != '0) begin
            deq_lv = LVL_3;
        end else if (cnt_reg[LVL_2] != '0) begin
            deq_lv = LVL_2;
        end else begin
            deq_lv = LVL_1;
        end

        status = STAT_OK;
        do_enq = 1'b0;
        do_deq = 1'b0;
        unique case (op_code)
            OP_ENQ: begin
                if (total_reg >= CNT_W'(DEPTH)) begin
                    status = STAT_FULL;
                end else if (op_priority == PRIO_NONE) begin
                    status = STAT_BADPRIO;
                end else begin
                    do_enq = 1'b1;
                end
            end
            OP_DEQ: begin
                if (total_reg == '0) begin
                    status = STAT_EMPTY;
                end else begin
                    do_deq = 1'b1;
                end
            end
            default: status = STAT_OK;
        endcase

        if (do_enq) begin
            total_next = total_reg + 1'b1;
        end else if (do_deq) begin
            total_next = total_reg - 1'b1;
        end else begin
            total_next = total_reg;
        end

        lv_sel  = do_enq ? enq_lv : deq_lv;
        ptr     = do_enq ? tail_reg[lv_sel] : head_reg[lv_sel];
        ptr_adv = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
    end

    assign mem_addr     = ADDR_W'(lv_sel) * ADDR_W'(DEPTH) + ADDR_W'(ptr);
    assign mem_wdata    = op_value;
    assign mem_op.wr_en = op_accept & do_enq;
    assign mem_op.rd_en = op_accept & do_deq;

    // total count reported modulo 32
    assign total_wide  = (CNT_W + 5)'(total_next);
    assign resp.status = status;
    assign resp.total  = total_wide[COUNT_W-1:0];
    assign resp.deq_ok = do_deq;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LEVELS; i++) begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
            total_reg <= '0;
        end else if (op_accept) begin
            total_reg <= total_next;
            if (do_enq) begin
                tail_reg[lv_sel] <= ptr_adv;
                cnt_reg[lv_sel]  <= cnt_reg[lv_sel] + 1'b1;
            end
            if (do_deq) begin
                head_reg[lv_sel] <= ptr_adv;
                cnt_reg[lv_sel]  <= cnt_reg[lv_sel] - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/three_level_priority_fifo_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// three_level_priority_fifo_unit: strict priority queue over three FIFO rings
//
// Usage: each slave item is an enqueue (s_tuser = 0) carrying a value and a
// priority 1..3, or a dequeue (s_tuser = 1). Three rings share DEPTH slots in
// total; a dequeue returns the oldest value of the highest non-empty level.
// Every item yields exactly one master item: value (zero unless a dequeue
// succeeded), status in m_tuser (ok, full, empty, bad priority) and the total
// number of stored values after the item. Errors leave the queue unchanged.
// Pipeline: the decision, pointer update and store read all happen at the
// accepting edge, which loads the middle stage; the result register then loads
// from the middle stage once it is free, and m_tvalid follows the result register.
// Throughput: one item per cycle while the master side is not stalled; each item
// updates its ring pointers at the accepting edge and uses one store port.
// Reset (aresetn low, synchronous) empties all rings and drops any item in
// flight; the store contents need no clearing.
// When the receiver stalls, the result register holds and one more item can
// sit in the middle stage; s_tready then falls until the master side drains.
// ----------------------------------------------------------------------------
module three_level_priority_fifo_unit #(
    parameter int DEPTH = tlpf_pkg::DEPTH_DEFAULT
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [31:0] item_value, [33:32] item_priority, rest zero
    input  wire logic [tlpf_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] opcode
    input  wire logic [0:0]                       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [31:0] out_value, [36:32] total_count, rest zero
    output logic [tlpf_pkg::M_TDATA_W-1:0]        m_tdata,
    // [1:0] status
    output logic [tlpf_pkg::STATUS_W-1:0]         m_tuser
);
    import tlpf_pkg::*;

    localparam int ADDR_W = $clog2(LEVELS * DEPTH);

    logic                 accept;
    tlpf_memop_t          mem_op;
    logic [ADDR_W-1:0]    mem_addr;
    logic [VALUE_W-1:0]   mem_wdata;
    logic [VALUE_W-1:0]   mem_rdata;
    tlpf_resp_t           resp;

    // middle stage: decision waiting for the store read data
    logic                 mid_valid_reg;
    logic                 mid_valid_next;
    tlpf_resp_t           mid_resp_reg;
    logic                 mid_advance;

    // result register
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [VALUE_W-1:0]   out_value_reg;
    tlpf_status_t         out_status_reg;
    logic [COUNT_W-1:0]   out_count_reg;

    assign mid_advance = mid_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready    = ~mid_valid_reg | ~out_valid_reg | m_tready;
    assign accept      = s_tvalid & s_tready;

    tlpf_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .op_accept   (accept),
        .op_code     (tlpf_op_t'(s_tuser)),
        .op_value    (s_tdata[VALUE_W-1:0]),
        .op_priority (s_tdata[VALUE_W +: PRIO_W]),
        .mem_op      (mem_op),
        .mem_addr    (mem_addr),
        .mem_wdata   (mem_wdata),
        .resp        (resp)
    );

    // one slot region per level, ring of level L starts at (L-1)*DEPTH
    tlpf_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(LEVELS * DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_op.wr_en),
        .wr_addr (mem_addr),
        .wr_data (mem_wdata),
        .rd_en   (mem_op.rd_en),
        .rd_addr (mem_addr),
        .rd_data (mem_rdata)
    );

    always_comb begin
        // advance the middle stage when the result register frees up
        if (accept) begin
            mid_valid_next = 1'b1;
        end else if (mid_advance) begin
            mid_valid_next = 1'b0;
        end else begin
            mid_valid_next = mid_valid_reg;
        end

        if (mid_advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            mid_valid_reg <= mid_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: hold unless a new item moves in
    always_ff @(posedge aclk) begin
        if (accept) begin
            mid_resp_reg <= resp;
        end
        if (mid_advance) begin
            out_value_reg  <= mid_resp_reg.deq_ok ? mem_rdata : '0;
            out_status_reg <= mid_resp_reg.status;
            out_count_reg  <= mid_resp_reg.total;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = M_TDATA_W'({out_count_reg, out_value_reg});

endmodule
`default_nettype wire

// ===== rtl/core/tlpf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlpf_checker: port-level checks for the three-level priority FIFO
// Watch the result channel for stall behavior and status consistency.
// ----------------------------------------------------------------------------
module tlpf_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_tready,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [tlpf_pkg::M_TDATA_W-1:0]   m_tdata,
    input wire logic [tlpf_pkg::STATUS_W-1:0]    m_tuser
);
    import tlpf_pkg::*;

    // a stalled result holds valid and payload
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    // any failed item carries a zero value
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STAT_OK |-> m_tdata[VALUE_W-1:0] == '0)
        else $error("error result with nonzero value");

    // an empty report means nothing is stored
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STAT_EMPTY |-> m_tdata[VALUE_W +: COUNT_W] == '0)
        else $error("empty status with nonzero count");

    // an unstalled result side never blocks the input
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input blocked while result side free");

    // reset drops any pending result
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind three_level_priority_fifo_unit tlpf_checker u_tlpf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

// ===== bench/tlpf_queue_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpf_queue_checker: result predictor and comparator for the priority FIFO
// Mirrors the three rings from the accepted slave items and compares each
// accepted master item, field by field, with the oldest predicted result.
// ----------------------------------------------------------------------------
module tlpf_queue_checker
    import tlpf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    // [31:0] item_value, [33:32] item_priority, rest zero
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // [0] opcode
    input  wire logic [0:0]           s_tuser,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    // [31:0] out_value, [36:32] total_count, rest zero
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    // [1:0] status
    input  wire logic [STATUS_W-1:0]  m_tuser,
    output int                        mismatches,
    output int                        pending_results
);

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        tlpf_status_t              status;
        logic [COUNT_W-1:0]        total;
    } queue_result_t;

    // mirror of the rings
    logic [VALUE_W-1:0] ring_mem [LEVELS][DEPTH];
    int                 rd_pos   [LEVELS];
    int                 wr_pos   [LEVELS];
    int                 held     [LEVELS];
    int                 held_total;

    queue_result_t      awaited_results [$];

    function automatic void clear_rings();
        for (int l = 0; l < LEVELS; l++) begin
            rd_pos[l] = 0;
            wr_pos[l] = 0;
            held[l]   = 0;
        end
        held_total = 0;
    endfunction

    // Apply one queue operation to the mirror and return what the block owes.
    function automatic queue_result_t apply_queue_op(tlpf_op_t op,
                                                     logic [VALUE_W-1:0] value,
                                                     logic [PRIO_W-1:0] prio);
        queue_result_t res;
        int            lv;
        res.value  = '0;
        res.status = STAT_OK;
        if (op == OP_ENQ) begin
            // full is checked ahead of the priority
            if (held_total >= DEPTH) begin
                res.status = STAT_FULL;
            end else if (prio == PRIO_NONE) begin
                res.status = STAT_BADPRIO;
            end else begin
                lv = int'(prio) - 1;
                ring_mem[lv][wr_pos[lv]] = value;
                wr_pos[lv] = (wr_pos[lv] + 1) % DEPTH;
                held[lv]++;
                held_total++;
            end
        end else begin
            lv = -1;
            if (held[LVL_3] != 0)      lv = LVL_3;
            else if (held[LVL_2] != 0) lv = LVL_2;
            else if (held[LVL_1] != 0) lv = LVL_1;
            if (lv < 0) begin
                res.status = STAT_EMPTY;
            end else begin
                res.value  = ring_mem[lv][rd_pos[lv]];
                rd_pos[lv] = (rd_pos[lv] + 1) % DEPTH;
                held[lv]--;
                held_total--;
            end
        end
        res.total = COUNT_W'(held_total);
        return res;
    endfunction

    function automatic void flag_field(string field, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : watch
        queue_result_t want;
        logic signed [VALUE_W-1:0] got_value;
        if (!aresetn) begin
            clear_rings();
            awaited_results.delete();
            pending_results <= 0;
        end else begin
            // retire the oldest prediction first; it belongs to an earlier item
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("result item with no prediction waiting");
                    mismatches++;
                end else begin
                    want      = awaited_results.pop_front();
                    got_value = m_tdata[VALUE_W-1:0];
                    flag_field("out_value", longint'(want.value), longint'(got_value));
                    flag_field("status", longint'(want.status), longint'(m_tuser));
                    flag_field("total_count", longint'(want.total),
                               longint'(m_tdata[VALUE_W +: COUNT_W]));
                end
            end
            if (s_tvalid && s_tready)
                awaited_results.push_back(apply_queue_op(tlpf_op_t'(s_tuser),
                                                         s_tdata[VALUE_W-1:0],
                                                         s_tdata[VALUE_W +: PRIO_W]));
            pending_results <= awaited_results.size();
        end
    end

endmodule

// ===== bench/tb_three_level_priority_fifo_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_level_priority_fifo_unit: regression bench for the priority FIFO
// Drives directed corner items and then phased random enqueue/dequeue traffic
// in bursts, throttles the result side, and leaves prediction and comparison
// to the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module tb_three_level_priority_fifo_unit;
    import tlpf_pkg::*;

    localparam int QUEUE_DEPTH  = DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 930;
    // cycles with no item moving on either side before giving up
    localparam int QUIET_LIMIT  = 4000;
    // settle time after the last result
    localparam int TAIL_CYCLES  = 12;

    // traffic mixes for the random phases
    typedef enum int { MIX_FILL, MIX_DRAIN, MIX_EVEN } traffic_mix_t;
    // receiver behavior per segment
    typedef enum int { DRAIN_STREAM, DRAIN_CHOPPY, DRAIN_SLOW } drain_mode_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // [31:0] item_value, [33:32] item_priority, rest zero
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // [0] opcode
    logic [0:0]           s_tuser  = OP_ENQ;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [31:0] out_value, [36:32] total_count, rest zero
    logic [M_TDATA_W-1:0] m_tdata;
    // [1:0] status
    logic [STATUS_W-1:0]  m_tuser;

    int mismatches;
    int pending_results;
    int quiet_cycles = 0;
    int burst_left   = 0;

    always #5 aclk = ~aclk;

    three_level_priority_fifo_unit #(
        .DEPTH(QUEUE_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    tlpf_queue_checker #(
        .DEPTH(QUEUE_DEPTH)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatches     (mismatches),
        .pending_results(pending_results)
    );

    // Count cycles in which nothing is accepted on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Watchdog: end the run if traffic stops for too long.
    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge aclk);
        $display("Regression FAIL");
        $finish;
    end

    // Pick a 32-bit value, leaning on the signed extremes now and then.
    function automatic logic [VALUE_W-1:0] extreme_value(int idx);
        case (idx % 4)
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 7) == 0)
            return extreme_value($urandom_range(0, 3));
        return $urandom;
    endfunction

    // Offer one item, hold it until accepted, then pace the next one:
    // keep valid high inside a burst, drop it for a random gap between bursts.
    task automatic push_item(tlpf_op_t op, logic [VALUE_W-1:0] value,
                             logic [PRIO_W-1:0] prio);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[VALUE_W-1:0]      = value;
        word[VALUE_W +: PRIO_W] = prio;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (burst_left == 0) begin
            // idle with junk on the bus; the block must ignore it
            word = '0;
            word[VALUE_W +: PRIO_W] = PRIO_W'($urandom_range(0, 3));
            word[VALUE_W-1:0]       = $urandom;
            s_tvalid <= 1'b0;
            s_tdata  <= word;
            s_tuser  <= 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            // mostly short bursts, sometimes a long unbroken stretch
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(0, 20);
        end else begin
            burst_left--;
        end
    endtask

    // Receiver: stall on its own pattern, with long hold-offs so the block
    // backs up and drops s_tready while the sender keeps offering.
    initial begin : drain_side
        int          seg;
        drain_mode_t mode;
        seg = 0;
        @(posedge aclk);
        forever begin
            seg++;
            if (seg == 4 || $urandom_range(0, 29) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(200, 400)) @(posedge aclk);
            end else begin
                mode = drain_mode_t'($urandom_range(0, 2));
                repeat ($urandom_range(4, 40)) begin
                    case (mode)
                        DRAIN_STREAM: m_tready <= 1'b1;
                        DRAIN_CHOPPY: m_tready <= ($urandom_range(0, 1) == 1);
                        default:      m_tready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    initial begin : stimulus
        traffic_mix_t mix;
        int           enq_pct;
        int           phase_len;
        int           sent;
        tlpf_op_t     op;
        logic [PRIO_W-1:0] prio;

        // hold reset low at the start, then release it for good
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // dequeue from an empty queue
        push_item(OP_DEQ, $urandom, PRIO_W'($urandom_range(0, 3)));
        // enqueue with the invalid priority
        push_item(OP_ENQ, 32'h1234_5678, PRIO_NONE);
        // fill to capacity, spreading extremes over all three levels
        for (int i = 0; i < QUEUE_DEPTH; i++)
            push_item(OP_ENQ, extreme_value(i), PRIO_W'(i % 3 + 1));
        // full is reported ahead of the invalid priority
        push_item(OP_ENQ, 32'h7FFF_FFFF, PRIO_NONE);
        push_item(OP_ENQ, 32'h8000_0000, 2'd3);
        // a few dequeues show the strict level order
        repeat (4) push_item(OP_DEQ, $urandom, PRIO_W'($urandom_range(0, 3)));

        // Random phases: fill-heavy and drain-heavy runs walk the queue
        // between full and empty so every ring wraps many times.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            mix       = traffic_mix_t'($urandom_range(0, 2));
            phase_len = $urandom_range(10, 60);
            case (mix)
                MIX_FILL:  enq_pct = 85;
                MIX_DRAIN: enq_pct = 20;
                default:   enq_pct = 50;
            endcase
            repeat (phase_len) begin
                op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
                if (op == OP_ENQ && $urandom_range(0, 15) != 0)
                    prio = PRIO_W'($urandom_range(1, 3));
                else
                    prio = PRIO_W'($urandom_range(0, 3));
                push_item(op, pick_value(), prio);
                sent++;
            end
        end

        // stop offering, wait for every predicted result, then let it settle
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0 && pending_results == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
